FILE: rtl/bmpp_pkg.sv
// Shared types and constants for the BLE MIDI packet parser.
package bmpp_pkg;

   localparam logic [1:0] PH_STAMP  = 2'd0;
   localparam logic [1:0] PH_STATUS = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
   localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
   localparam logic [2:0] KIND_REALTIME = 3'd7;

   localparam logic [7:0] BYTE_RT_FIRST  = 8'hF8;
   localparam logic [7:0] BYTE_SYSEX_END = 8'hF7;
   localparam logic [7:0] BYTE_SYSEX     = 8'hF0;
   localparam logic [7:0] BYTE_LAST_CHAN = 8'hEF;
   localparam logic [3:0] NIB_PROGRAM    = 4'hC;
   localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;

   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [7:0]  status_byte;
      logic [12:0] stamp;
      logic [6:0]  second_data;
      logic [7:0]  first_data;
      logic [4:0]  channel_number;
      logic [2:0]  event_kind;
   } result_type;

endpackage

FILE: rtl/ble_midi_packet_parser.sv
// BLE MIDI packet parser top level.
// Takes one packet byte per transaction (req_tuser marks the header byte) and
// emits decoded channel and real-time events. One byte is accepted every cycle
// unless back-pressure stalls the input; a byte is registered on entry and
// decoded from the input register straight into the result register. Bytes
// that complete no event produce no transaction. Back-pressure on the result
// stream stalls input only when both the input and result registers are full.
module ble_midi_packet_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // byte_in
   input  logic                                req_tuser,  // packet_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // channel_number[4:0], first_data[12:5], second_data[19:13], stamp[32:20],
   // status_byte[40:33], zero fill[47:41]
   output logic [bmpp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [2:0]                          rsp_tuser   // event_kind
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_start_ff;
   logic                 out_ready;
   logic                 advance;
   logic                 res_valid;
   bmpp_pkg::result_type res;

   assign advance     = in_valid_ff && out_ready;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   bmpp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .byte_in      (in_byte_ff),
      .packet_start (in_start_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   bmpp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .res        (res),
      .ready      (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/bmpp_parser.sv
// Packet parse state and per-byte event decode.
module bmpp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            byte_in,
   input  logic                  packet_start,
   output logic                  res_valid,
   output bmpp_pkg::result_type  res
);

   logic [1:0]  phase_ff,   phase_in;
   logic        skip_ff,    skip_in;
   logic [7:0]  running_ff, running_in;
   logic [7:0]  current_ff, current_in;
   logic [1:0]  held_ff,    held_in;
   logic [1:0]  needed_ff,  needed_in;
   logic [6:0]  held0_ff,   held0_in;
   logic [6:0]  held1_ff,   held1_in;
   logic [5:0]  high_ff,    high_in;
   logic [12:0] stamp_ff,   stamp_in;
   logic        sysex_ff,   sysex_in;

   function automatic logic [1:0] need_for(input logic [7:0] st);
      logic [1:0] n;
      n = ((st[7:4] == bmpp_pkg::NIB_PROGRAM) || (st[7:4] == bmpp_pkg::NIB_CHAN_PRESS))
          ? 2'd1 : 2'd2;
      return n;
   endfunction

   always_comb begin
      logic       go;
      logic       run;
      logic       emit_ch;
      logic [6:0] d1;
      logic [6:0] d2;
      logic [2:0] kind;
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      running_in = running_ff;
      current_in = current_ff;
      held_in    = held_ff;
      needed_in  = needed_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      high_in    = high_ff;
      stamp_in   = stamp_ff;
      sysex_in   = sysex_ff;
      go         = 1'b0;
      run        = 1'b0;
      emit_ch    = 1'b0;
      d1         = '0;
      d2         = '0;
      kind       = '0;
      res_valid  = 1'b0;
      res        = '0;

      if (fire) begin
         if (packet_start) begin
            if (byte_in[7]) begin
               high_in    = byte_in[5:0];
               stamp_in   = {byte_in[5:0], 7'd0};
               running_in = '0;
               current_in = '0;
               held_in    = '0;
               needed_in  = '0;
               sysex_in   = 1'b0;
               phase_in   = bmpp_pkg::PH_STAMP;
               skip_in    = 1'b0;
            end else begin
               skip_in = 1'b1;
            end
         end else if (!skip_ff) begin
            if ((phase_ff != bmpp_pkg::PH_STAMP) && (byte_in >= bmpp_pkg::BYTE_RT_FIRST)) begin
               res_valid           = 1'b1;
               res.event_kind      = bmpp_pkg::KIND_REALTIME;
               res.channel_number  = '0;
               res.first_data      = byte_in;
               res.second_data     = '0;
               res.stamp           = stamp_ff;
               res.status_byte     = byte_in;
            end else begin
               go = 1'b1;
               if (sysex_ff) begin
                  if (byte_in == bmpp_pkg::BYTE_SYSEX_END) begin
                     sysex_in = 1'b0;
                     phase_in = bmpp_pkg::PH_STAMP;
                  end else if (byte_in[7]) begin
                     sysex_in = 1'b0;
                  end else begin
                     go = 1'b0;
                  end
               end
               if (go) begin
                  unique case (phase_in)
                     bmpp_pkg::PH_STAMP: begin
                        if (byte_in[7]) begin
                           stamp_in = {high_ff, byte_in[6:0]};
                           phase_in = bmpp_pkg::PH_STATUS;
                        end else if (running_ff != '0) begin
                           run = 1'b1;
                        end
                     end
                     bmpp_pkg::PH_STATUS: begin
                        if (byte_in[7]) begin
                           if (byte_in == bmpp_pkg::BYTE_SYSEX) begin
                              sysex_in   = 1'b1;
                              running_in = '0;
                           end else if (byte_in <= bmpp_pkg::BYTE_LAST_CHAN) begin
                              current_in = byte_in;
                              running_in = byte_in;
                              needed_in  = need_for(byte_in);
                              held_in    = '0;
                              phase_in   = bmpp_pkg::PH_DATA;
                           end else begin
                              running_in = '0;
                              phase_in   = bmpp_pkg::PH_STAMP;
                           end
                        end else if (running_ff != '0) begin
                           run = 1'b1;
                        end else begin
                           phase_in = bmpp_pkg::PH_STAMP;
                        end
                     end
                     bmpp_pkg::PH_DATA: begin
                        if (!byte_in[7]) begin
                           if (held_ff < 2'd2) begin
                              if (held_ff[0]) held1_in = byte_in[6:0];
                              else            held0_in = byte_in[6:0];
                              held_in = held_ff + 2'd1;
                           end
                           if (held_in == needed_ff) begin
                              emit_ch  = 1'b1;
                              phase_in = bmpp_pkg::PH_STAMP;
                           end
                        end else begin
                           stamp_in = {high_ff, byte_in[6:0]};
                           phase_in = bmpp_pkg::PH_STATUS;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (run) begin
                  current_in = running_ff;
                  needed_in  = need_for(running_ff);
                  held0_in   = byte_in[6:0];
                  held_in    = 2'd1;
                  if (needed_in == 2'd1) begin
                     emit_ch  = 1'b1;
                     phase_in = bmpp_pkg::PH_STAMP;
                  end else begin
                     phase_in = bmpp_pkg::PH_DATA;
                  end
               end
               if (emit_ch) begin
                  d1   = (held_in >= 2'd1) ? held0_in : 7'd0;
                  d2   = (held_in >= 2'd2) ? held1_in : 7'd0;
                  kind = current_in[6:4];
                  if ((kind == bmpp_pkg::KIND_NOTE_ON) && (d2 == 7'd0))
                     kind = bmpp_pkg::KIND_NOTE_OFF;
                  res_valid          = 1'b1;
                  res.event_kind     = kind;
                  res.channel_number = {1'b0, current_in[3:0]} + 5'd1;
                  res.first_data     = {1'b0, d1};
                  res.second_data    = d2;
                  res.stamp          = stamp_ff;
                  res.status_byte    = current_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bmpp_pkg::PH_STAMP;
         skip_ff    <= 1'b0;
         running_ff <= '0;
         current_ff <= '0;
         held_ff    <= '0;
         needed_ff  <= '0;
         high_ff    <= '0;
         stamp_ff   <= '0;
         sysex_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         skip_ff    <= skip_in;
         running_ff <= running_in;
         current_ff <= current_in;
         held_ff    <= held_in;
         needed_ff  <= needed_in;
         high_ff    <= high_in;
         stamp_ff   <= stamp_in;
         sysex_ff   <= sysex_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

   a_chan_back_to_stamp: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.event_kind != bmpp_pkg::KIND_REALTIME))
      |=> (phase_ff == bmpp_pkg::PH_STAMP))
      else $error("channel message did not return to timestamp phase");

   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && packet_start && byte_in[7])
      |=> (!sysex_ff && (running_ff == '0) && !skip_ff))
      else $error("valid header did not clear parse state");

   a_skip_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && skip_ff && !packet_start)
      |=> ($stable(phase_ff) && $stable(running_ff) && !$past(res_valid)))
      else $error("skipped packet byte changed state");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bmpp_pkg::PH_DATA) |-> ((held_ff < needed_ff) && current_ff[7]))
      else $error("data phase with inconsistent byte counts");

endmodule

FILE: rtl/bmpp_out_reg.sv
// Result register driving the response stream.
module bmpp_out_reg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  bmpp_pkg::result_type                  res,
   output logic                                  ready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bmpp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [2:0]                            rsp_tuser
);

   logic                 valid_ff, valid_in;
   bmpp_pkg::result_type res_ff;

   assign ready    = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.event_kind;
   assign rsp_tdata  = {7'd0, res_ff.status_byte, res_ff.stamp, res_ff.second_data,
                        res_ff.first_data, res_ff.channel_number};

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the BLE MIDI packet parser: directed table plus random packets.
`timescale 1ns / 1ps

module testbench;

   localparam logic [2:0] KIND_PITCH_BEND = 3'd6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 155;
   localparam int HOLD_CYCLES = 250;
   localparam bmpp_pkg::result_type NO_EV = '0;

   typedef struct packed {
      logic [7:0]           data;
      logic                 hdr;
      logic                 pinned;
      bmpp_pkg::result_type ev;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       hdr;
   } midi_item_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = '0;   // byte_in
   logic                            req_tuser = 1'b0; // packet_start
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // channel_number[4:0], first_data[12:5], second_data[19:13], stamp[32:20],
   // status_byte[40:33], zero fill[47:41]
   logic [bmpp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                      rsp_tuser;        // event_kind

   // sideband for directed rows whose event is typed into the table
   logic                 pin_flag = 1'b0;
   bmpp_pkg::result_type pin_value = '0;

   int  send_idle = 0;
   int  stall_pct = 0;
   bit  hold_go = 1'b0;
   bit  hold_off = 1'b0;
   int  mismatches = 0;
   int  cycle_count = 0;

   bmpp_pkg::result_type pending_events[$];
   midi_item_type        pkt_q[$];

   // decoder state
   logic [1:0] dec_phase;
   bit         skip_rest;
   logic [7:0] run_st;
   logic [7:0] cur_st;
   logic [1:0] n_held;
   logic [1:0] n_need;
   logic [6:0] held_b [2];
   logic [5:0] ts_hi;
   logic [12:0] ts_now;
   bit         in_sysex;

   stim_row_type dir_tab [41] = '{
      {8'h85, 1'b0, 1'b0, NO_EV},
      {8'h90, 1'b0, 1'b0, NO_EV},
      {8'h3C, 1'b0, 1'b0, NO_EV},
      {8'h40, 1'b0, 1'b0, NO_EV},
      {8'h3C, 1'b0, 1'b0, NO_EV},
      {8'h00, 1'b0, 1'b1, {8'h90, 13'd5, 7'd0, 8'h3C, 5'd1, bmpp_pkg::KIND_NOTE_OFF}},
      {8'hBF, 1'b1, 1'b0, NO_EV},
      {8'hFF, 1'b0, 1'b0, NO_EV},
      {8'hFE, 1'b0, 1'b1, {8'hFE, 13'h1FFF, 7'd0, 8'hFE, 5'd0, bmpp_pkg::KIND_REALTIME}},
      {8'hEF, 1'b0, 1'b0, NO_EV},
      {8'h7F, 1'b0, 1'b0, NO_EV},
      {8'h7F, 1'b0, 1'b1, {8'hEF, 13'h1FFF, 7'h7F, 8'h7F, 5'd16, KIND_PITCH_BEND}},
      {8'h05, 1'b0, 1'b0, NO_EV},
      {8'h40, 1'b0, 1'b0, NO_EV},
      {8'h81, 1'b0, 1'b0, NO_EV},
      {8'hF0, 1'b0, 1'b0, NO_EV},
      {8'h12, 1'b0, 1'b0, NO_EV},
      {8'hF7, 1'b0, 1'b0, NO_EV},
      {8'hF0, 1'b0, 1'b0, NO_EV},
      {8'hC5, 1'b0, 1'b0, NO_EV},
      {8'h10, 1'b0, 1'b0, NO_EV},
      {8'h80, 1'b0, 1'b0, NO_EV},
      {8'hA0, 1'b0, 1'b0, NO_EV},
      {8'h90, 1'b0, 1'b0, NO_EV},
      {8'hD0, 1'b0, 1'b0, NO_EV},
      {8'h7F, 1'b0, 1'b0, NO_EV},
      {8'hFF, 1'b0, 1'b0, NO_EV},
      {8'h8F, 1'b0, 1'b0, NO_EV},
      {8'h00, 1'b0, 1'b0, NO_EV},
      {8'h00, 1'b0, 1'b1, {8'h8F, 13'h1FFF, 7'd0, 8'h00, 5'd16, bmpp_pkg::KIND_NOTE_OFF}},
      {8'hB1, 1'b0, 1'b0, NO_EV},
      {8'hB1, 1'b0, 1'b0, NO_EV},
      {8'h40, 1'b0, 1'b0, NO_EV},
      {8'h41, 1'b0, 1'b0, NO_EV},
      {8'h00, 1'b1, 1'b0, NO_EV},
      {8'h95, 1'b0, 1'b0, NO_EV},
      {8'hC0, 1'b1, 1'b0, NO_EV},
      {8'h80, 1'b1, 1'b0, NO_EV},
      {8'hF3, 1'b0, 1'b0, NO_EV},
      {8'hF3, 1'b0, 1'b0, NO_EV},
      {8'h11, 1'b0, 1'b0, NO_EV}
   };

   int idle_tab [4] = '{0, 86, 0, 25};
   int stall_tab [4] = '{0, 0, 86, 25};

   ble_midi_packet_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic logic [1:0] data_len(input logic [7:0] st);
      return (st[7:4] == bmpp_pkg::NIB_PROGRAM || st[7:4] == bmpp_pkg::NIB_CHAN_PRESS)
             ? 2'd1 : 2'd2;
   endfunction

   function automatic bmpp_pkg::result_type channel_event();
      logic [6:0] d1;
      logic [6:0] d2;
      bmpp_pkg::result_type ev;
      d1 = (n_held >= 2'd1) ? held_b[0] : 7'd0;
      d2 = (n_held >= 2'd2) ? held_b[1] : 7'd0;
      ev.event_kind = cur_st[6:4];
      if (ev.event_kind == bmpp_pkg::KIND_NOTE_ON && d2 == 7'd0)
         ev.event_kind = bmpp_pkg::KIND_NOTE_OFF;
      ev.channel_number = {1'b0, cur_st[3:0]} + 5'd1;
      ev.first_data = {1'b0, d1};
      ev.second_data = d2;
      ev.stamp = ts_now;
      ev.status_byte = cur_st;
      return ev;
   endfunction

   task automatic clear_decoder();
      dec_phase = bmpp_pkg::PH_STAMP;
      skip_rest = 1'b0;
      run_st = '0;
      cur_st = '0;
      n_held = '0;
      n_need = '0;
      held_b[0] = '0;
      held_b[1] = '0;
      ts_hi = '0;
      ts_now = '0;
      in_sysex = 1'b0;
   endtask

   task automatic take_running(input logic [7:0] b, output bit hit,
                               output bmpp_pkg::result_type ev);
      cur_st = run_st;
      n_need = data_len(cur_st);
      held_b[0] = b[6:0];
      n_held = 2'd1;
      if (n_held == n_need) begin
         ev = channel_event();
         hit = 1'b1;
         dec_phase = bmpp_pkg::PH_STAMP;
      end else begin
         dec_phase = bmpp_pkg::PH_DATA;
      end
   endtask

   task automatic decode_midi_byte(input logic [7:0] b, input logic hdr,
                                   output bit hit, output bmpp_pkg::result_type ev);
      bit swallowed;
      hit = 1'b0;
      ev = '0;
      swallowed = 1'b0;
      if (hdr) begin
         if (b[7]) begin
            ts_hi = b[5:0];
            ts_now = {b[5:0], 7'd0};
            run_st = '0;
            cur_st = '0;
            n_held = '0;
            n_need = '0;
            in_sysex = 1'b0;
            dec_phase = bmpp_pkg::PH_STAMP;
            skip_rest = 1'b0;
         end else begin
            skip_rest = 1'b1;
         end
      end else if (!skip_rest) begin
         if (dec_phase != bmpp_pkg::PH_STAMP && b >= bmpp_pkg::BYTE_RT_FIRST) begin
            hit = 1'b1;
            ev.event_kind = bmpp_pkg::KIND_REALTIME;
            ev.channel_number = '0;
            ev.first_data = b;
            ev.second_data = '0;
            ev.stamp = ts_now;
            ev.status_byte = b;
         end else begin
            if (in_sysex) begin
               if (b == bmpp_pkg::BYTE_SYSEX_END) begin
                  in_sysex = 1'b0;
                  dec_phase = bmpp_pkg::PH_STAMP;
               end else if (b[7]) begin
                  in_sysex = 1'b0;
               end else begin
                  swallowed = 1'b1;
               end
            end
            if (!swallowed) begin
               case (dec_phase)
                  bmpp_pkg::PH_STAMP: begin
                     if (b[7]) begin
                        ts_now = {ts_hi, b[6:0]};
                        dec_phase = bmpp_pkg::PH_STATUS;
                     end else if (run_st != 8'd0) begin
                        take_running(b, hit, ev);
                     end
                  end
                  bmpp_pkg::PH_STATUS: begin
                     if (b[7]) begin
                        if (b == bmpp_pkg::BYTE_SYSEX) begin
                           in_sysex = 1'b1;
                           run_st = '0;
                        end else if (b <= bmpp_pkg::BYTE_LAST_CHAN) begin
                           cur_st = b;
                           run_st = b;
                           n_need = data_len(b);
                           n_held = '0;
                           dec_phase = bmpp_pkg::PH_DATA;
                        end else begin
                           run_st = '0;
                           dec_phase = bmpp_pkg::PH_STAMP;
                        end
                     end else if (run_st != 8'd0) begin
                        take_running(b, hit, ev);
                     end else begin
                        dec_phase = bmpp_pkg::PH_STAMP;
                     end
                  end
                  bmpp_pkg::PH_DATA: begin
                     if (!b[7]) begin
                        if (n_held < 2'd2) begin
                           held_b[n_held[0]] = b[6:0];
                           n_held = n_held + 2'd1;
                        end
                        if (n_held == n_need) begin
                           ev = channel_event();
                           hit = 1'b1;
                           dec_phase = bmpp_pkg::PH_STAMP;
                        end
                     end else begin
                        ts_now = {ts_hi, b[6:0]};
                        dec_phase = bmpp_pkg::PH_STATUS;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_event(input bmpp_pkg::result_type got,
                              input bmpp_pkg::result_type want);
      if (got.event_kind !== want.event_kind)
         flag_mismatch("event_kind", 16'(got.event_kind), 16'(want.event_kind));
      if (got.channel_number !== want.channel_number)
         flag_mismatch("channel_number", 16'(got.channel_number),
                       16'(want.channel_number));
      if (got.first_data !== want.first_data)
         flag_mismatch("first_data", 16'(got.first_data), 16'(want.first_data));
      if (got.second_data !== want.second_data)
         flag_mismatch("second_data", 16'(got.second_data), 16'(want.second_data));
      if (got.stamp !== want.stamp)
         flag_mismatch("stamp", 16'(got.stamp), 16'(want.stamp));
      if (got.status_byte !== want.status_byte)
         flag_mismatch("status_byte", 16'(got.status_byte), 16'(want.status_byte));
   endtask

   always @(posedge clock) begin
      bmpp_pkg::result_type got;
      bmpp_pkg::result_type ev;
      bit hit;
      if (reset) begin
         clear_decoder();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.event_kind = rsp_tuser;
            got.channel_number = rsp_tdata[4:0];
            got.first_data = rsp_tdata[12:5];
            got.second_data = rsp_tdata[19:13];
            got.stamp = rsp_tdata[32:20];
            got.status_byte = rsp_tdata[40:33];
            if (pending_events.size() == 0)
               flag_mismatch("event with none pending, status", 16'(got.status_byte),
                             16'd0);
            else
               check_event(got, pending_events.pop_front());
         end
         if (req_tvalid && req_tready) begin
            decode_midi_byte(req_tdata, req_tuser, hit, ev);
            if (hit) pending_events.push_back(pin_flag ? pin_value : ev);
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // long receiver hold-off while the sender runs at full rate
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_byte(input logic [7:0] b, input logic hdr, input logic pinned,
                            input bmpp_pkg::result_type pin_ev);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= hdr;
      pin_flag <= pinned;
      pin_value <= pin_ev;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put(input logic [7:0] b);
      pkt_q.push_back({b, 1'b0});
   endtask

   task automatic put_stamp();
      put({1'b1, 7'($urandom_range(127))});
   endtask

   task automatic put_data();
      put({1'b0, 7'($urandom_range(127))});
   endtask

   function automatic logic [7:0] rand_status();
      return {1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))};
   endfunction

   task automatic build_packet();
      int pick;
      logic [7:0] st;
      if ($urandom_range(99) < 8) begin
         pkt_q.push_back({8'($urandom_range(127)), 1'b1});
         repeat ($urandom_range(4)) put(8'($urandom_range(255)));
      end else begin
         pkt_q.push_back({1'b1, 7'($urandom_range(127)), 1'b1});
         repeat ($urandom_range(4)) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               put_stamp();
               st = rand_status();
               put(st);
               if ($urandom_range(99) < 15) put(8'($urandom_range(8'hFF, 8'hF8)));
               put_data();
               if (data_len(st) == 2'd2) begin
                  if ($urandom_range(4) == 0) put(8'h00);
                  else put_data();
               end
            end else if (pick < 70) begin
               if ($urandom_range(1)) put_stamp();
               repeat ($urandom_range(2, 1)) put_data();
            end else if (pick < 78) begin
               put(8'($urandom_range(8'hFF, 8'hF8)));
            end else if (pick < 86) begin
               put_stamp();
               put(bmpp_pkg::BYTE_SYSEX);
               repeat ($urandom_range(3)) put_data();
               put($urandom_range(1) ? bmpp_pkg::BYTE_SYSEX_END : rand_status());
            end else if (pick < 92) begin
               put_stamp();
               put(8'($urandom_range(8'hF7, 8'hF1)));
            end else begin
               put(8'($urandom_range(255)));
            end
         end
      end
   endtask

   initial begin
      int sent;
      midi_item_type it;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[i])
         send_byte(dir_tab[i].data, dir_tab[i].hdr, dir_tab[i].pinned, dir_tab[i].ev);

      for (int ph = 0; ph < 4; ph++) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         send_idle = idle_tab[ph];
         stall_pct = stall_tab[ph];
         if (ph == 0) hold_go = 1'b1;
         @(negedge clock);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_packet();
            if (pkt_q[0].data[7]) sent += pkt_q.size();
            while (pkt_q.size() != 0) begin
               it = pkt_q.pop_front();
               send_byte(it.data, it.hdr, 1'b0, NO_EV);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending_events.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
